[rtl/sfcp_pkg.sv]
// shared types, constants and the crc byte update for the scope frame packer
`default_nettype none
package sfcp_pkg;

  localparam int CHAN_W      = 16;
  localparam int NUM_CHANS   = 4;
  localparam int ITEM_W      = CHAN_W * NUM_CHANS;
  localparam int BYTE_W      = 8;
  localparam int DATA_BYTES  = ITEM_W / BYTE_W;
  localparam int FRAME_LEN   = DATA_BYTES + 2;
  localparam int IDX_W       = $clog2(FRAME_LEN);
  localparam int SEL_W       = $clog2(DATA_BYTES);

  localparam logic [CHAN_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CHAN_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  // one accepted item, chan_zero in the low bits
  typedef struct packed {
    logic signed [CHAN_W-1:0] chan_three;
    logic signed [CHAN_W-1:0] chan_two;
    logic signed [CHAN_W-1:0] chan_one;
    logic signed [CHAN_W-1:0] chan_zero;
  } sfcp_item_t;

  // queue status toward the back end
  typedef struct packed {
    logic valid;
    logic full;
  } sfcp_qstat_t;

  // crc-16/modbus update by one byte, lsb first
  function automatic logic [CHAN_W-1:0] crc_byte(input logic [CHAN_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [CHAN_W-1:0] c;
    c = crc_in ^ {{(CHAN_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/scope_frame_crc16_packer.sv]
// top level of the scope frame packer with crc-16/modbus trailer
`default_nettype none
// Each input transfer carries four 16-bit channel samples and turns into a
// ten-byte frame on the output stream: every channel little-endian (low byte
// then high byte) in channel order, then the crc-16/modbus of those eight
// bytes (init 0xffff, reflected poly 0xa001, no final xor), low byte first.
// out_tlast marks the tenth byte. A two-entry queue takes input transfers
// while the serializer is busy; the serializer emits one byte per cycle while
// out_tready does not stall it and updates the crc by one byte per data byte,
// so with a queued item and no stall there is no gap between frames. An input
// transfer into an idle block passes the queue, the serializer's frame register
// and the output register to its first byte. No state is kept between frames.
module scope_frame_crc16_packer
  import sfcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // chan_zero, chan_one, chan_two, chan_three
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // frame_byte
  output logic             out_tlast   // frame_end
);

  sfcp_qstat_t q_stat;
  sfcp_item_t  q_item;
  sfcp_item_t  in_item;
  logic        push;
  logic        pop;

  // input transfer lands in the queue whenever it has room
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;
  assign in_item   = sfcp_item_t'(in_tdata);

  sfcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head_item (q_item),
    .stat      (q_stat)
  );

  // back end: byte sequencing, crc and the output register
  sfcp_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("serializer popped an empty queue");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("input accepted while queue full");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> q_stat.valid)
    else $error("pushed item not visible in queue");
`endif

endmodule
`default_nettype wire

[rtl/sfcp_queue.sv]
// two-entry item queue between the input side and the frame serializer
`default_nettype none
module sfcp_queue
  import sfcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire sfcp_item_t  push_item,
  input  wire logic        pop,
  output sfcp_item_t       head_item,
  output sfcp_qstat_t      stat
);

  sfcp_item_t  mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = mem_r[rd_ptr_r];
  assign stat.valid = (count_r != 2'd0);
  assign stat.full  = count_r[1];

endmodule
`default_nettype wire

[rtl/sfcp_serializer.sv]
// frame serializer: sends channel bytes, folds them into the running crc, then sends the crc
`default_nettype none
module sfcp_serializer
  import sfcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfcp_qstat_t        q_stat,
  input  wire sfcp_item_t         q_item,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [BYTE_W-1:0]       out_tdata,
  output logic                    out_tlast
);

  logic [ITEM_W-1:0]  frame_r, frame_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CHAN_W-1:0]  crc_r, crc_nxt;
  logic               busy_r, busy_nxt;
  logic               oval_r, oval_nxt;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic               olast_r, olast_nxt;
  logic               emit;
  logic               at_last;
  logic [BYTE_W-1:0]  data_byte;
  logic [BYTE_W-1:0]  cur_byte;

  assign emit      = busy_r && (!oval_r || out_tready);
  assign at_last   = (idx_r == IDX_LAST);
  assign data_byte = frame_r[{idx_r[SEL_W-1:0], 3'b000} +: BYTE_W];
  assign pop       = q_stat.valid && (!busy_r || (emit && at_last));

  always_comb begin
    if (idx_r < IDX_CRC_LO) begin
      cur_byte = data_byte;
    end else if (idx_r == IDX_CRC_LO) begin
      cur_byte = crc_r[BYTE_W-1:0];
    end else begin
      cur_byte = crc_r[CHAN_W-1:BYTE_W];
    end
  end

  always_comb begin
    frame_nxt = frame_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    busy_nxt  = busy_r;
    oval_nxt  = oval_r && !out_tready;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (emit) begin
      oval_nxt  = 1'b1;
      obyte_nxt = cur_byte;
      olast_nxt = at_last;
      idx_nxt   = idx_r + IDX_W'(1);
      if (idx_r < IDX_CRC_LO) begin
        crc_nxt = crc_byte(crc_r, data_byte);
      end
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      frame_nxt = q_item;
      idx_nxt   = '0;
      crc_nxt   = CRC_INIT;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    crc_r   <= crc_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire
